// ===== rtl/core/pthe_pkg.sv =====
// pthe_pkg: types, constants and saturation helpers for the P1 triangle heat element.
// Used by every module under rtl/core; depends on nothing.
package pthe_pkg;

  localparam int NUM_W   = 96;          // divider numerator width
  localparam int DEN_W   = 64;          // divider denominator width
  localparam int QUO_W   = 32;          // divider quotient width
  localparam int DIV_LAT = QUO_W + 1;   // divider latency in cycles

  localparam logic signed [31:0] POS_MAX = 32'sh7FFF_FFFF;
  localparam logic [63:0] LIM_POS   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIM_NEG   = 64'h0000_0000_8000_0000;

  // source share: (|q|*|D| >> 33) / 3 by reciprocal multiplication
  localparam logic [61:0] SHARE_BIG = 62'd3 << 32;           // quotient reaches 2^32
  localparam logic [33:0] RECIP3    = 34'd11453246123;       // ceil(2^35 / 3)
  localparam int          RECIP3_SH = 35;

  localparam logic [1:0] LAST_IDX = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] REG_COND = 2'd0;
  localparam logic [1:0] REG_CAP  = 2'd1;
  localparam logic [1:0] REG_DT   = 2'd2;

  localparam logic [30:0] CFG_RESET = 31'd65536;

  typedef logic signed [31:0] q16_t;

  typedef struct packed {
    q16_t vertex_a_x;
    q16_t vertex_a_y;
    q16_t vertex_b_x;
    q16_t vertex_b_y;
    q16_t vertex_c_x;
    q16_t vertex_c_y;
    q16_t temp_a;
    q16_t temp_b;
    q16_t temp_c;
    q16_t source_density;
  } in_item_t;

  typedef struct packed {
    logic [1:0] local_row;
    logic [1:0] local_col;
    q16_t       coefficient;
    q16_t       history_term;
    q16_t       source_share;
    logic       degenerate;
    logic       last;
  } out_item_t;

  // one (i,j) element handed from the sequencer to the element pipe
  typedef struct packed {
    logic        valid;
    logic [1:0]  row;
    logic [1:0]  col;
    logic        deg;
    logic        last;
    q16_t        nu_i;
    q16_t        nu_j;
    q16_t        nv_i;
    q16_t        nv_j;
    q16_t        temp_j;
    logic [62:0] dmag;
    logic [31:0] qmag;
    logic        qneg;
  } issue_t;

  // sideband that rides along the element pipe
  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic       deg;
    logic       last;
    q16_t       temp_j;
    logic       qneg;
    logic       dneg;
  } tag_t;

  function automatic q16_t sat_diff(input q16_t a, input q16_t b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d > 33'sd2147483647) sat_diff = POS_MAX;
    else if (d < -33'sd2147483647) sat_diff = -POS_MAX;
    else sat_diff = d[31:0];
  endfunction

  // signed result from sign and magnitude, clamped to 32 bits
  function automatic q16_t sat_mag(input logic neg, input logic [63:0] m);
    logic [63:0] lim;
    logic [31:0] v;
    lim = neg ? LIM_NEG : LIM_POS;
    v = (m > lim) ? lim[31:0] : m[31:0];
    sat_mag = neg ? -v : v;
  endfunction

  function automatic q16_t sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) sat33 = POS_MAX;
    else if (v < -33'sd2147483648) sat33 = -POS_MAX - 32'sd1;
    else sat33 = v[31:0];
  endfunction

endpackage

// ===== rtl/core/pthe_div.sv =====
// pthe_div: pipelined restoring divider, 96-bit by 64-bit, 32 quotient bits.
// One quotient bit per stage plus an overflow stage; uses pthe_pkg.
module pthe_div import pthe_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [QUO_W-1:0] quo,
  output logic             ovf
);

  logic [DEN_W-1:0] rem_r [0:QUO_W];
  logic [QUO_W-1:0] low_r [0:QUO_W];
  logic [DEN_W-1:0] den_r [0:QUO_W];
  logic [QUO_W-1:0] quo_r [0:QUO_W];
  logic             ovf_r [0:QUO_W];

  logic [DEN_W:0] trial [0:QUO_W-1];
  logic [DEN_W:0] diff  [0:QUO_W-1];
  logic [QUO_W-1:0] take;

  always_comb begin
    for (int s = 0; s < QUO_W; s++) begin
      trial[s] = {rem_r[s], low_r[s][QUO_W-1]};
      diff[s]  = trial[s] - {1'b0, den_r[s]};
      take[s]  = trial[s] >= {1'b0, den_r[s]};
    end
  end

  always_ff @(posedge clk) begin
    // quotient needs more than 32 bits when num >= den * 2^32
    rem_r[0] <= num[NUM_W-1:QUO_W];
    low_r[0] <= num[QUO_W-1:0];
    den_r[0] <= den;
    quo_r[0] <= '0;
    ovf_r[0] <= num >= {den, {QUO_W{1'b0}}};
    for (int s = 0; s < QUO_W; s++) begin
      rem_r[s+1] <= take[s] ? diff[s][DEN_W-1:0] : trial[s][DEN_W-1:0];
      low_r[s+1] <= {low_r[s][QUO_W-2:0], 1'b0};
      den_r[s+1] <= den_r[s];
      quo_r[s+1] <= {quo_r[s][QUO_W-2:0], take[s]};
      ovf_r[s+1] <= ovf_r[s];
    end
  end

  assign quo = quo_r[QUO_W];
  assign ovf = ovf_r[QUO_W];

endmodule

// ===== rtl/core/pthe_front.sv =====
// pthe_front: edge normals, determinant and the (i,j) sequencer of one triangle.
// Three geometry stages then a sequencer issuing nine elements (one if degenerate); uses pthe_pkg.
module pthe_front import pthe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_item_t item,
  output logic     busy,
  output issue_t   iss
);

  typedef struct packed {
    q16_t [2:0]  nu;
    q16_t [2:0]  nv;
    q16_t [2:0]  temp;
    logic [31:0] qmag;
    logic        qneg;
  } geo_t;

  geo_t geo_nxt;
  geo_t geo_a_r, geo_b_r, geo_c_r, geo_s_r;
  logic va_r, vb_r, vc_r;
  logic signed [63:0] p1_r, p2_r, dd_r, dd_abs;
  logic [62:0] dmag_r;
  logic deg_r, act_r;
  logic [1:0] row_r, col_r;
  logic accept, last;

  assign accept = start && !busy;

  always_comb begin
    geo_nxt.nu[0]   = sat_diff(item.vertex_b_y, item.vertex_c_y);
    geo_nxt.nv[0]   = sat_diff(item.vertex_c_x, item.vertex_b_x);
    geo_nxt.nu[1]   = sat_diff(item.vertex_c_y, item.vertex_a_y);
    geo_nxt.nv[1]   = sat_diff(item.vertex_a_x, item.vertex_c_x);
    geo_nxt.nu[2]   = sat_diff(item.vertex_a_y, item.vertex_b_y);
    geo_nxt.nv[2]   = sat_diff(item.vertex_b_x, item.vertex_a_x);
    geo_nxt.temp[0] = item.temp_a;
    geo_nxt.temp[1] = item.temp_b;
    geo_nxt.temp[2] = item.temp_c;
    geo_nxt.qneg    = item.source_density[31];
    geo_nxt.qmag    = item.source_density[31] ? (~item.source_density + 32'd1)
                                              : item.source_density;
  end

  assign dd_abs = dd_r[63] ? -dd_r : dd_r;

  // payload stages
  always_ff @(posedge clk) begin
    geo_a_r <= geo_nxt;
    geo_b_r <= geo_a_r;
    p1_r    <= 64'($signed(geo_a_r.nv[2])) * 64'($signed(geo_a_r.nu[1]));
    p2_r    <= 64'($signed(geo_a_r.nu[2])) * 64'($signed(geo_a_r.nv[1]));
    geo_c_r <= geo_b_r;
    dd_r    <= p1_r - p2_r;
    if (vc_r) begin
      geo_s_r <= geo_c_r;
      dmag_r  <= dd_abs[62:0];
    end
  end

  assign last = deg_r || (row_r == LAST_IDX && col_r == LAST_IDX);

  // control: stage valids and the row/col sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
      act_r <= 1'b0;
      deg_r <= 1'b0;
      row_r <= '0;
      col_r <= '0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
      vc_r <= vb_r;
      if (vc_r) begin
        act_r <= 1'b1;
        deg_r <= dd_r == '0;
        row_r <= '0;
        col_r <= '0;
      end else if (act_r) begin
        if (last) begin
          act_r <= 1'b0;
        end else if (col_r == LAST_IDX) begin
          col_r <= '0;
          row_r <= row_r + 2'd1;
        end else begin
          col_r <= col_r + 2'd1;
        end
      end
    end
  end

  // take a new triangle once at most four elements remain, so it lands
  // in the sequencer right after the current one ends
  assign busy = va_r || vb_r || vc_r ||
                (act_r && !deg_r &&
                 (row_r == 2'd0 || (row_r == 2'd1 && col_r != LAST_IDX)));

  always_comb begin
    iss.valid  = act_r;
    iss.row    = row_r;
    iss.col    = col_r;
    iss.deg    = deg_r;
    iss.last   = last;
    iss.nu_i   = geo_s_r.nu[row_r];
    iss.nu_j   = geo_s_r.nu[col_r];
    iss.nv_i   = geo_s_r.nv[row_r];
    iss.nv_j   = geo_s_r.nv[col_r];
    iss.temp_j = geo_s_r.temp[col_r];
    iss.dmag   = dmag_r;
    iss.qmag   = geo_s_r.qmag;
    iss.qneg   = geo_s_r.qneg;
  end

endmodule

// ===== rtl/core/pthe_elem.sv =====
// pthe_elem: per-element datapath: products, two pipelined dividers, saturation.
// Depends on pthe_pkg and pthe_div.
module pthe_elem import pthe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  issue_t      iss,
  input  logic [30:0] cond,
  input  logic [30:0] cap,
  input  logic [30:0] dt,
  output logic        out_valid,
  output out_item_t   out_item
);

  logic [31:0] cw;
  logic [30:0] dte;
  logic [34:0] d12;
  logic [63:0] mden_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  tag_t tg1_r, tg2_r, tg3_r, tg4_r, tg5_r;
  logic [62:0] dmag1_r, dmag2_r, dmag3_r, dmag4_r;
  logic signed [63:0] pa_r, pb_r, dot_r;
  logic [63:0] ml_r, sl_r;
  logic [62:0] mh_r, sh_r, dotm_r;
  logic [NUM_W-1:0] mnum2_r, mnum3_r, mnum4_r, mnum5_r;
  logic [NUM_W-1:0] snum2_r;
  logic [33:0] sx3_r;
  logic        sbig3_r, sbig4_r;
  logic [67:0] sp4_r;
  logic [31:0] squo;
  q16_t        shr5_r;
  q16_t        shd_r [0:DIV_LAT-1];
  logic [NUM_W-1:0] knum_r;
  logic [63:0] kl_r, kden_r;
  logic [61:0] kh_r;
  logic [QUO_W-1:0] mq, kq;
  logic mo, ko;
  logic vd_r [0:DIV_LAT-1];
  tag_t tgd_r [0:DIV_LAT-1];
  logic vf1_r, vf2_r;
  tag_t tgf1_r, tgf2_r;
  q16_t mdt_r, stf_r, shr1_r, shr2_r, coef_r;
  logic signed [63:0] prod_r, prod_abs;
  logic [63:0] hmag;
  out_item_t out_nxt, out_r;
  logic out_valid_r;

  // mass over dt divisor: 12 * dt * 2^17, zero step taken as one
  assign dte = (dt == '0) ? 31'd1 : dt;
  assign d12 = {1'b0, dte, 3'b0} + {2'b0, dte, 2'b0};
  assign cw  = (iss.row == iss.col) ? {cap, 1'b0} : {1'b0, cap};

  // share quotient below 2^32 once the big case is excluded
  assign squo = sp4_r[RECIP3_SH+31:RECIP3_SH];

  always_ff @(posedge clk) begin
    mden_r <= 64'({d12, 17'b0});
    // P1: partial products
    tg1_r   <= '{row: iss.row, col: iss.col, deg: iss.deg, last: iss.last,
                 temp_j: iss.temp_j, qneg: iss.qneg, dneg: 1'b0};
    dmag1_r <= iss.dmag;
    pa_r    <= 64'($signed(iss.nu_i)) * 64'($signed(iss.nu_j));
    pb_r    <= 64'($signed(iss.nv_i)) * 64'($signed(iss.nv_j));
    ml_r    <= 64'(cw) * 64'(iss.dmag[31:0]);
    mh_r    <= 63'(cw) * 63'(iss.dmag[62:32]);
    sl_r    <= 64'(iss.qmag) * 64'(iss.dmag[31:0]);
    sh_r    <= 63'(iss.qmag) * 63'(iss.dmag[62:32]);
    // P2: sums
    tg2_r   <= tg1_r;
    dmag2_r <= dmag1_r;
    dot_r   <= pa_r + pb_r;
    mnum2_r <= NUM_W'(ml_r) + NUM_W'({mh_r, 32'b0});
    snum2_r <= NUM_W'(sl_r) + NUM_W'({sh_r, 32'b0});
    // P3: sign and magnitude of the dot product; share shifted down
    tg3_r      <= '{row: tg2_r.row, col: tg2_r.col, deg: tg2_r.deg, last: tg2_r.last,
                    temp_j: tg2_r.temp_j, qneg: tg2_r.qneg, dneg: dot_r[63]};
    dmag3_r    <= dmag2_r;
    dotm_r     <= dot_r[63] ? 63'(-dot_r) : dot_r[62:0];
    mnum3_r    <= mnum2_r;
    sbig3_r    <= snum2_r[NUM_W-2:33] >= SHARE_BIG;
    sx3_r      <= snum2_r[66:33];
    // P4: stiffness partial products, share reciprocal product
    tg4_r   <= tg3_r;
    dmag4_r <= dmag3_r;
    kl_r    <= 64'(cond) * 64'(dotm_r[31:0]);
    kh_r    <= 62'(cond) * 62'(dotm_r[62:32]);
    mnum4_r <= mnum3_r;
    sbig4_r <= sbig3_r;
    sp4_r   <= 68'(sx3_r) * 68'(RECIP3);
    // P5: divider operands, saturated share
    tg5_r   <= tg4_r;
    knum_r  <= NUM_W'(kl_r) + NUM_W'({kh_r, 32'b0});
    kden_r  <= {dmag4_r, 1'b0};
    mnum5_r <= mnum4_r;
    shr5_r  <= sat_mag(tg4_r.qneg, sbig4_r ? '1 : 64'(squo));
    // sideband across the dividers
    tgd_r[0] <= tg5_r;
    shd_r[0] <= shr5_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      tgd_r[k] <= tgd_r[k-1];
      shd_r[k] <= shd_r[k-1];
    end
    // F1: saturate quotients
    tgf1_r <= tgd_r[DIV_LAT-1];
    mdt_r  <= sat_mag(1'b0, mo ? '1 : 64'(mq));
    stf_r  <= sat_mag(tgd_r[DIV_LAT-1].dneg, ko ? '1 : 64'(kq));
    shr1_r <= shd_r[DIV_LAT-1];
    // F2: coefficient and history product
    tgf2_r <= tgf1_r;
    coef_r <= sat33(33'($signed(mdt_r)) + 33'($signed(stf_r)));
    prod_r <= 64'($signed(mdt_r)) * 64'($signed(tgf1_r.temp_j));
    shr2_r <= shr1_r;
    // F3: result register
    out_r  <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) vd_r[k] <= 1'b0;
      vf1_r       <= 1'b0;
      vf2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r  <= iss.valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      v4_r  <= v3_r;
      v5_r  <= v4_r;
      vd_r[0] <= v5_r;
      for (int k = 1; k < DIV_LAT; k++) vd_r[k] <= vd_r[k-1];
      vf1_r <= vd_r[DIV_LAT-1];
      vf2_r <= vf1_r;
      out_valid_r <= vf2_r;
    end
  end

  pthe_div u_mdiv (.clk(clk), .num(mnum5_r), .den(mden_r), .quo(mq), .ovf(mo));
  pthe_div u_kdiv (.clk(clk), .num(knum_r),  .den(kden_r), .quo(kq), .ovf(ko));

  // history term truncates toward zero
  assign prod_abs = prod_r[63] ? -prod_r : prod_r;
  assign hmag     = 64'(prod_abs) >> 16;

  always_comb begin
    out_nxt.degenerate = tgf2_r.deg;
    out_nxt.last       = tgf2_r.last;
    if (tgf2_r.deg) begin
      out_nxt.local_row    = '0;
      out_nxt.local_col    = '0;
      out_nxt.coefficient  = '0;
      out_nxt.history_term = '0;
      out_nxt.source_share = '0;
    end else begin
      out_nxt.local_row    = tgf2_r.row;
      out_nxt.local_col    = tgf2_r.col;
      out_nxt.coefficient  = coef_r;
      out_nxt.history_term = sat_mag(prod_r[63], hmag);
      out_nxt.source_share = (tgf2_r.col == 2'd0) ? shr2_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== rtl/core/p1_triangle_heat_element.sv =====
// p1_triangle_heat_element: P1 triangle heat-conduction element.
// Items pass the geometry stages and the sequencer, then element stages P1-P5, the
// dividers and F1-F3; results come one per cycle (a degenerate triangle gives a single
// result). A new item is taken once at most four elements of the last one remain.
// Reset (rst_n low, synchronous) empties the pipe; registers return to 1.0.
// Depends on pthe_pkg, pthe_front, pthe_elem, pthe_div. Results cannot be stalled.
module p1_triangle_heat_element import pthe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  // results
  output logic        out_valid,
  output out_item_t   out_data,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [30:0] cond_r, cap_r, dt_r;
  logic        cfg_wr;
  issue_t      iss;

  // Register file: conductivity, heat capacity, time step at 0x0, 0x4, 0x8.
  // Writes outside the map are dropped; only 31 data bits are kept.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cond_r <= CFG_RESET;
      cap_r  <= CFG_RESET;
      dt_r   <= CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_COND: cond_r <= pwdata[30:0];
        REG_CAP:  cap_r  <= pwdata[30:0];
        REG_DT:   dt_r   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COND: prdata = {1'b0, cond_r};
      REG_CAP:  prdata = {1'b0, cap_r};
      REG_DT:   prdata = {1'b0, dt_r};
      default:  prdata = '0;
    endcase
  end

  // Geometry front end: saturated edge normals, determinant, then the sequencer walks
  // the nine (i,j) pairs in row-major order (a single one for a degenerate triangle).
  pthe_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .item  (in_data),
    .busy  (busy),
    .iss   (iss)
  );

  // Element pipe: mass/dt and stiffness through pipelined dividers, source share by
  // reciprocal multiplication, then saturation and the history product.
  pthe_elem u_elem (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss       (iss),
    .cond      (cond_r),
    .cap       (cap_r),
    .dt        (dt_r),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  // an accepted item holds the input off on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("input not held off after accept");

  // a degenerate triangle is a single, closing, zeroed item
  a_degen_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |-> out_data.last && out_data.coefficient == '0)
    else $error("degenerate result malformed");

  // a regular triangle closes on pair (2,2)
  a_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last && !out_data.degenerate |->
      out_data.local_row == LAST_IDX && out_data.local_col == LAST_IDX)
    else $error("last flag on wrong pair");

  // the nine results of one triangle come back to back
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |=> out_valid)
    else $error("gap inside a triangle's results");

endmodule
